FILE: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int PORT_PAGE_W = 16;   // width of page fields on the ports
    localparam int FRAME_W     = 2;    // width of the reported frame index
    localparam int COUNT_W     = 32;   // hit and fault totals
    localparam int IDX_W       = 4;    // frame index, up to 16 frames
    localparam int RANK_W      = 4;    // recency rank, up to 16 frames

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // search results rippling along the row of cells
    typedef struct packed {
        logic              hit_seen;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              empty_seen;
        logic [IDX_W-1:0]  empty_idx;
        logic [RANK_W-1:0] max_rank;
        logic [IDX_W-1:0]  max_idx;
    } chain_t;

    // update broadcast to every cell
    typedef struct packed {
        logic              en;          // transaction accepted
        logic              clear;       // end of sequence: back to reset state
        logic              write;       // miss: load the page into the target
        logic [IDX_W-1:0]  target;
        logic              age_all;     // target was empty: every valid frame ages
        logic [RANK_W-1:0] limit_rank;  // otherwise frames newer than this age
    } upd_t;

endpackage

`default_nettype wire

FILE: rtl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame: page, valid bit and recency rank, with its link of the search
// chain (first hit, first empty frame, oldest frame).
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell #(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire logic [PAGE_BITS-1:0]    req_page,
    input  wire lrupr_pkg::chain_t       chain_in,
    input  wire logic [PAGE_BITS-1:0]    victim_page_in,
    output lrupr_pkg::chain_t            chain_out,
    output logic [PAGE_BITS-1:0]         victim_page_out,
    input  wire lrupr_pkg::upd_t         upd
);

    localparam logic [lrupr_pkg::IDX_W-1:0] MY_IDX = lrupr_pkg::IDX_W'(IDX);

    logic [PAGE_BITS-1:0]         page_reg,  page_next;
    logic                         valid_reg, valid_next;
    logic [lrupr_pkg::RANK_W-1:0] rank_reg,  rank_next;
    logic                         match;

    assign match = valid_reg && (page_reg == req_page);

    always_comb
    begin
        chain_out       = chain_in;
        victim_page_out = victim_page_in;
        if (match && !chain_in.hit_seen)
        begin
            chain_out.hit_seen = 1'b1;
            chain_out.hit_idx  = MY_IDX;
            chain_out.hit_rank = rank_reg;
        end
        if (!valid_reg && !chain_in.empty_seen)
        begin
            chain_out.empty_seen = 1'b1;
            chain_out.empty_idx  = MY_IDX;
        end
        // first cell seeds the oldest-frame search; ties keep the lower index
        if ((IDX == 0) || (rank_reg > chain_in.max_rank))
        begin
            chain_out.max_rank = rank_reg;
            chain_out.max_idx  = MY_IDX;
            victim_page_out    = page_reg;
        end
    end

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.clear)
        begin
            page_next  = '0;
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (upd.en)
        begin
            if (upd.target == MY_IDX)
            begin
                rank_next  = '0;
                valid_next = 1'b1;
                if (upd.write)
                begin
                    page_next = req_page;
                end
            end
            else if (valid_reg && (upd.age_all || (rank_reg < upd.limit_rank)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            page_reg  <= page_next;
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
// An accepted request's result is loaded into the output register in the next cycle.
// Throughput: one request per cycle while in_stall is low; lookup, victim choice and recency
// update ripple combinationally through the row of frame cells.
// Reset: all frames empty, ranks and totals zero; a request flagged as last
// returns the block to this state once its result is produced.
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU frame set with saturating hit and fault totals.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = 4,
    parameter int PAGE_BITS = 16
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          in_valid,
    output logic                                         in_stall,
    input  wire logic [lrupr_pkg::PORT_PAGE_W-1:0]       page,
    input  wire                                          last_request,
    output logic                                         out_valid,
    input  wire                                          out_stall,
    output logic                                         hit,
    output logic [lrupr_pkg::FRAME_W-1:0]                frame,
    output logic                                         evicted_valid,
    output logic [lrupr_pkg::PORT_PAGE_W-1:0]            evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]                hit_count,
    output logic [lrupr_pkg::COUNT_W-1:0]                fault_count,
    output logic                                         totals_final
);

    localparam int PW = lrupr_pkg::PORT_PAGE_W;
    localparam int CW = lrupr_pkg::COUNT_W;

    logic                     in_fire;
    logic [PAGE_BITS+PW-1:0]  page_ext;
    logic [PAGE_BITS-1:0]     req_page;
    lrupr_pkg::chain_t        links [FRAMES+1];
    logic [PAGE_BITS-1:0]     vlinks [FRAMES+1];
    lrupr_pkg::chain_t        found;
    lrupr_pkg::upd_t          upd;
    logic                     is_hit;
    logic                     evict;
    logic [lrupr_pkg::IDX_W-1:0] target;
    logic [PAGE_BITS+PW-1:0]  victim_ext;

    logic              out_valid_reg, out_valid_next;
    logic              hit_reg;
    logic [lrupr_pkg::FRAME_W-1:0] frame_reg;
    logic              ev_valid_reg;
    logic [PW-1:0]     ev_page_reg;
    logic              final_reg;
    logic [CW-1:0]     hit_total_reg,   hit_total_next;
    logic [CW-1:0]     fault_total_reg, fault_total_next;
    logic [CW-1:0]     hit_sum, fault_sum;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // page compared on its low PAGE_BITS bits, zero-extended when wider
    assign page_ext = {{PAGE_BITS{1'b0}}, page};
    assign req_page = page_ext[PAGE_BITS-1:0];

    assign links[0]  = '0;
    assign vlinks[0] = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lrupr_cell #(
            .IDX       (i),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .req_page        (req_page),
            .chain_in        (links[i]),
            .victim_page_in  (vlinks[i]),
            .chain_out       (links[i+1]),
            .victim_page_out (vlinks[i+1]),
            .upd             (upd)
        );
    end

    assign found = links[FRAMES];
    assign is_hit = found.hit_seen;
    assign evict  = !found.hit_seen && !found.empty_seen;

    always_comb
    begin
        priority if (found.hit_seen)
        begin
            target = found.hit_idx;
        end
        else if (found.empty_seen)
        begin
            target = found.empty_idx;
        end
        else
        begin
            target = found.max_idx;
        end
    end

    always_comb
    begin
        upd.en         = in_fire;
        upd.clear      = in_fire && last_request;
        upd.write      = !is_hit;
        upd.target     = target;
        upd.age_all    = !is_hit && found.empty_seen;
        upd.limit_rank = is_hit ? found.hit_rank : found.max_rank;
    end

    assign victim_ext = {{PW{1'b0}}, vlinks[FRAMES]};

    assign hit_sum   = (hit_total_reg == lrupr_pkg::COUNT_MAX) ?
                       hit_total_reg : hit_total_reg + 1'b1;
    assign fault_sum = (fault_total_reg == lrupr_pkg::COUNT_MAX) ?
                       fault_total_reg : fault_total_reg + 1'b1;

    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        hit_total_next   = hit_total_reg;
        fault_total_next = fault_total_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            if (last_request)
            begin
                hit_total_next   = '0;
                fault_total_next = '0;
            end
            else if (is_hit)
            begin
                hit_total_next = hit_sum;
            end
            else
            begin
                fault_total_next = fault_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            hit_total_reg   <= '0;
            fault_total_reg <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            hit_total_reg   <= hit_total_next;
            fault_total_reg <= fault_total_next;
        end
    end

    // result payload; totals include this transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hit_reg      <= is_hit;
            frame_reg    <= target[lrupr_pkg::FRAME_W-1:0];
            ev_valid_reg <= evict;
            ev_page_reg  <= evict ? victim_ext[PW-1:0] : '0;
            final_reg    <= last_request;
            hit_count    <= is_hit ? hit_sum : hit_total_reg;
            fault_count  <= is_hit ? fault_total_reg : fault_sum;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame         = frame_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign totals_final  = final_reg;

endmodule

`default_nettype wire
